/* design/pfsc_pkg.sv */
// Shared types, constants and arctangent table for the path-following steering pipeline.
// No dependencies.
`default_nettype none
package pfsc_pkg;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 31;
    localparam logic [1:0] REG_HEADING_GAIN = 2'd0;
    localparam logic [1:0] REG_LATERAL_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_SPEED_LIMIT = 2'd2;
    localparam logic [1:0] REG_SPIN_LIMIT = 2'd3;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    localparam logic [25:0] PI_Q24 = 26'd52707179;

    typedef struct packed {
        logic [15:0] heading_gain;
        logic [30:0] lateral_threshold;
        logic [14:0] speed_limit;
        logic [14:0] spin_limit;
    } cfg_t;

    function automatic logic signed [33:0] atan_entry(input int i);
        logic signed [33:0] r;
        begin
            unique case (i)
                0: r = 34'sd536870912;
                1: r = 34'sd316933406;
                2: r = 34'sd167458907;
                3: r = 34'sd85004756;
                4: r = 34'sd42667331;
                5: r = 34'sd21354465;
                6: r = 34'sd10679838;
                7: r = 34'sd5340245;
                8: r = 34'sd2670163;
                9: r = 34'sd1335087;
                10: r = 34'sd667544;
                11: r = 34'sd333772;
                12: r = 34'sd166886;
                13: r = 34'sd83443;
                14: r = 34'sd41722;
                15: r = 34'sd20861;
                16: r = 34'sd10430;
                17: r = 34'sd5215;
                18: r = 34'sd2608;
                19: r = 34'sd1304;
                20: r = 34'sd652;
                21: r = 34'sd326;
                22: r = 34'sd163;
                23: r = 34'sd81;
                default: r = '0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

/* design/path_following_steering_control.sv */
// Top level of the path-following steering pipeline.
// Uses pfsc_pkg, pfsc_cordic_stage and pfsc_divider.
//
// Takes one word per cycle while the pipe advances and returns one word per item.
// The stages are the input register, the CORDIC stages (capped at 24 stages),
// rounding, products and error registers, one divider stage per strategy bit
// and the heading, pi-product and output registers.
// The whole pipe advances when the output register is empty or being taken.
`default_nettype none
module path_following_steering_control #(
    parameter int ANGLE_BITS = 16,
    parameter int POSITION_BITS = 32,
    parameter int SINCOS_STAGES = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [pfsc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [pfsc_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic signed [POSITION_BITS-1:0]  robot_x,
    input  wire logic signed [POSITION_BITS-1:0]  robot_y,
    input  wire logic signed [ANGLE_BITS-1:0]     robot_heading,
    input  wire logic signed [POSITION_BITS-1:0]  target_x,
    input  wire logic signed [POSITION_BITS-1:0]  target_y,
    input  wire logic signed [ANGLE_BITS-1:0]     target_heading,
    input  wire logic signed [15:0]               target_speed,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [14:0]                           speed_command,
    output logic signed [15:0]                    spin_command,
    output logic signed [31:0]                    lateral_error,
    output logic signed [ANGLE_BITS-1:0]          heading_command
);
    localparam int PB = POSITION_BITS;
    localparam int AB = ANGLE_BITS;
    localparam int NST = (SINCOS_STAGES < 24) ? SINCOS_STAGES : 24;
    localparam int DB = PB + 1;
    localparam int SIDE = 2 * DB + AB + AB + 1;
    localparam int QB = AB - 1;
    localparam int PRB = DB + 15;
    localparam int SUMB = PRB + 1;
    localparam int CW = (SUMB > 64) ? SUMB : 64;

    pfsc_pkg::cfg_t cfg_reg;
    logic advance;
    logic out_valid_reg;

    assign advance = !out_valid_reg || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.heading_gain <= 16'd256;
            cfg_reg.lateral_threshold <= 31'd65536;
            cfg_reg.speed_limit <= 15'd256;
            cfg_reg.spin_limit <= 15'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pfsc_pkg::REG_HEADING_GAIN: cfg_reg.heading_gain <= cfg_data[15:0];
                pfsc_pkg::REG_LATERAL_THRESHOLD: cfg_reg.lateral_threshold <= cfg_data;
                pfsc_pkg::REG_SPEED_LIMIT: cfg_reg.speed_limit <= cfg_data[14:0];
                pfsc_pkg::REG_SPIN_LIMIT: cfg_reg.spin_limit <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // stage 0: differences, angle pre-rotation
    logic v0_reg, flip_in;
    logic signed [DB-1:0] dx_in, dy_in;
    logic [31:0] ang32, ang_rot;
    logic signed [33:0] x0_reg, y0_reg, z0_reg;
    logic [SIDE-1:0] side0_reg, side0_next;

    always_comb
    begin
        dx_in = $signed({robot_x[PB-1], robot_x}) - $signed({target_x[PB-1], target_x});
        dy_in = $signed({robot_y[PB-1], robot_y}) - $signed({target_y[PB-1], target_y});
        ang32 = {target_heading, {(32 - AB){1'b0}}};
        flip_in = ang32[31] ^ ang32[30];
        ang_rot = flip_in ? {~ang32[31], ang32[30:0]} : ang32;
        side0_next = {dx_in, dy_in, target_heading, robot_heading, flip_in};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (advance)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x0_reg <= pfsc_pkg::CORDIC_X0;
            y0_reg <= '0;
            z0_reg <= {{2{ang_rot[31]}}, ang_rot};
            side0_reg <= side0_next;
        end
    end

    logic cv [NST+1];
    logic signed [33:0] cx [NST+1];
    logic signed [33:0] cy [NST+1];
    logic signed [33:0] cz [NST+1];
    logic [SIDE-1:0] cs [NST+1];

    assign cv[0] = v0_reg;
    assign cx[0] = x0_reg;
    assign cy[0] = y0_reg;
    assign cz[0] = z0_reg;
    assign cs[0] = side0_reg;

    for (genvar i = 0; i < NST; i++)
    begin : g_cordic
        pfsc_cordic_stage #(.STAGE(i), .SIDE_BITS(SIDE)) u_stage (
            .clk(clk), .rst_n(rst_n), .advance(advance),
            .valid_in(cv[i]), .x_in(cx[i]), .y_in(cy[i]), .z_in(cz[i]),
            .side_in(cs[i]),
            .valid_out(cv[i+1]), .x_out(cx[i+1]), .y_out(cy[i+1]),
            .z_out(cz[i+1]), .side_out(cs[i+1])
        );
    end

    // stage A: Q1.14 rounding
    logic va_reg;
    logic signed [15:0] c_reg, s_reg;
    logic [SIDE-1:0] sidea_reg;
    logic signed [33:0] xf, yf;

    function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [18:0] r;
        begin
            t = $signed({v[33], v}) + 35'sd32768;
            r = t[34:16];
            if (r > 19'sd16384)
                r = 19'sd16384;
            else if (r < -19'sd16384)
                r = -19'sd16384;
            return r[15:0];
        end
    endfunction

    assign xf = cs[NST][0] ? -cx[NST] : cx[NST];
    assign yf = cs[NST][0] ? -cy[NST] : cy[NST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (advance)
            va_reg <= cv[NST];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_reg <= to_q14(xf);
            s_reg <= to_q14(yf);
            sidea_reg <= cs[NST];
        end
    end

    // stage B: four products
    logic signed [DB-1:0] dxa, dya;
    logic vb_reg;
    logic signed [PRB-1:0] pyc_reg, pxs_reg, pxc_reg, pys_reg;
    logic [2*AB:0] sideb_reg;

    assign dxa = sidea_reg[SIDE-1 -: DB];
    assign dya = sidea_reg[SIDE-1-DB -: DB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (advance)
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pyc_reg <= PRB'(dya * c_reg);
            pxs_reg <= PRB'(dxa * s_reg);
            pxc_reg <= PRB'(dxa * c_reg);
            pys_reg <= PRB'(dya * s_reg);
            sideb_reg <= sidea_reg[2*AB:0];
        end
    end

    // target speed travels on its own delay line up to stage C
    localparam int SPD_DLY = NST + 3;
    logic [15:0] spd_reg [SPD_DLY];
    logic [15:0] target_speed_d;
    assign target_speed_d = spd_reg[SPD_DLY-1];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            spd_reg[0] <= target_speed;
            for (int k = 1; k < SPD_DLY; k++)
                spd_reg[k] <= spd_reg[k-1];
        end
    end

    // stage C: lateral error, along-path stop test, error magnitude and threshold
    logic vc_reg;
    logic signed [SUMB-1:0] lsum, tsum;
    logic signed [SUMB-15:0] lsh;
    logic signed [CW-1:0] lshw, tsw;
    logic signed [31:0] lat;
    logic signed [31:0] lat_reg;
    logic stop_next;
    logic [30:0] thr;
    logic [31:0] mag;
    logic [2*AB:0] sidec_reg;
    logic stop_reg;
    logic [31:0] mag_reg;
    logic [30:0] thr_reg;
    logic signed [CW-1:0] ten;

    assign ten = CW'(64'sd10 <<< 30);
    assign thr = (cfg_reg.lateral_threshold == '0) ? 31'd1 : cfg_reg.lateral_threshold;

    always_comb
    begin
        lsum = $signed({pyc_reg[PRB-1], pyc_reg}) - $signed({pxs_reg[PRB-1], pxs_reg})
            + SUMB'(8192);
        tsum = $signed({pxc_reg[PRB-1], pxc_reg}) + $signed({pys_reg[PRB-1], pys_reg});
        lsh = lsum[SUMB-1:14];
        lshw = CW'(lsh);
        tsw = CW'(tsum);
        if (lshw > CW'(64'sd2147483647))
            lat = 32'sh7fffffff;
        else if (lshw < CW'(-64'sd2147483648))
            lat = 32'sh80000000;
        else
            lat = lshw[31:0];
        mag = lat[31] ? 32'(-lat) : 32'(lat);
        stop_next = (target_speed_d == '0) && (tsw < ten) && (tsw > -ten);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else if (advance)
            vc_reg <= vb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lat_reg <= lat;
            stop_reg <= stop_next;
            mag_reg <= mag;
            thr_reg <= thr;
            sidec_reg <= sideb_reg;
        end
    end

    // divider: (mag*Q + thr/2) / thr when mag < thr, otherwise Q
    localparam int DSIDE = 32 + 1 + 1 + 2 * AB;
    logic full;
    logic [30+QB:0] num;
    logic [DSIDE-1:0] dside_in, dside_out;
    logic vd;
    logic [QB-1:0] quo;

    assign full = mag_reg >= {1'b0, thr_reg};
    assign num = full ? '0 : (((31+QB)'(mag_reg) << (AB - 2)) + (31+QB)'(thr_reg >> 1));
    assign dside_in = {lat_reg, stop_reg, full, sidec_reg[2*AB:1]};

    pfsc_divider #(.QBITS(QB), .DBITS(31), .SIDE_BITS(DSIDE)) u_div (
        .clk(clk), .rst_n(rst_n), .advance(advance),
        .valid_in(vc_reg), .num_in(num), .den_in(thr_reg),
        .side_in(dside_in),
        .valid_out(vd), .quo_out(quo), .side_out(dside_out)
    );

    // stage E: heading command, heading difference, gain product
    logic signed [31:0] lat_e;
    logic stop_e, full_e;
    logic [AB-1:0] th_e, rh_e, strat, hcmd, dd, absd;
    logic ve_reg;
    logic [AB-1:0] hcmd_reg;
    logic [AB+15:0] m_reg;
    logic dneg_reg, stop_e_reg;
    logic signed [31:0] lat_e_reg;

    assign lat_e = dside_out[DSIDE-1 -: 32];
    assign stop_e = dside_out[2*AB+1];
    assign full_e = dside_out[2*AB];
    assign th_e = dside_out[2*AB-1 -: AB];
    assign rh_e = dside_out[AB-1:0];

    always_comb
    begin
        strat = full_e ? (AB'(1) << (AB - 2)) : AB'(quo);
        if (lat_e > 0)
            strat = -strat;
        hcmd = strat + th_e;
        dd = hcmd - rh_e;
        absd = dd[AB-1] ? -dd : dd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ve_reg <= 1'b0;
        else if (advance)
            ve_reg <= vd;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hcmd_reg <= hcmd;
            m_reg <= (AB+16)'(cfg_reg.heading_gain) * (AB+16)'({1'b0, absd[AB-1:0]});
            dneg_reg <= dd[AB-1];
            stop_e_reg <= stop_e;
            lat_e_reg <= lat_e;
        end
    end

    // stage F: multiply by pi
    logic vf_reg, big_reg, dneg_f_reg, stop_f_reg;
    logic [AB+41:0] pm_reg;
    logic [AB-1:0] hcmd_f_reg;
    logic signed [31:0] lat_f_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vf_reg <= 1'b0;
        else if (advance)
            vf_reg <= ve_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            big_reg <= m_reg[AB+15 -: 2] != 2'b00;
            pm_reg <= (AB+42)'(m_reg[AB+13:0]) * (AB+42)'(pfsc_pkg::PI_Q24);
            dneg_f_reg <= dneg_reg;
            stop_f_reg <= stop_e_reg;
            hcmd_f_reg <= hcmd_reg;
            lat_f_reg <= lat_e_reg;
        end
    end

    // output register
    logic [AB+41:0] rsum;
    logic [18:0] spin_raw;
    logic [14:0] spin_mag;
    logic [14:0] speed_reg;
    logic signed [15:0] spin_reg;
    logic signed [31:0] lat_o_reg;
    logic [AB-1:0] hcmd_o_reg;

    always_comb
    begin
        rsum = pm_reg + ((AB+42)'(1) << (AB + 22));
        spin_raw = rsum[AB+41 -: 19];
        if (big_reg || spin_raw > 19'(cfg_reg.spin_limit))
            spin_mag = cfg_reg.spin_limit;
        else
            spin_mag = spin_raw[14:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= vf_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            speed_reg <= stop_f_reg ? 15'd0 : cfg_reg.speed_limit;
            spin_reg <= dneg_f_reg ? -$signed({1'b0, spin_mag}) : $signed({1'b0, spin_mag});
            lat_o_reg <= lat_f_reg;
            hcmd_o_reg <= hcmd_f_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign speed_command = speed_reg;
    assign spin_command = spin_reg;
    assign lateral_error = lat_o_reg;
    assign heading_command = hcmd_o_reg;
endmodule
`default_nettype wire

/* design/pfsc_cordic_stage.sv */
// One registered CORDIC rotation stage with side payload.
// Uses pfsc_pkg.
`default_nettype none
module pfsc_cordic_stage #(
    parameter int STAGE = 0,
    parameter int SIDE_BITS = 8
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    advance,
    input  wire logic                    valid_in,
    input  wire logic signed [33:0]      x_in,
    input  wire logic signed [33:0]      y_in,
    input  wire logic signed [33:0]      z_in,
    input  wire logic [SIDE_BITS-1:0]    side_in,
    output logic                         valid_out,
    output logic signed [33:0]           x_out,
    output logic signed [33:0]           y_out,
    output logic signed [33:0]           z_out,
    output logic [SIDE_BITS-1:0]         side_out
);
    logic valid_reg;
    logic signed [33:0] x_reg, y_reg, z_reg, x_next, y_next, z_next;
    logic [SIDE_BITS-1:0] side_reg;

    always_comb
    begin
        if (!z_in[33])
        begin
            x_next = x_in - (y_in >>> STAGE);
            y_next = y_in + (x_in >>> STAGE);
            z_next = z_in - pfsc_pkg::atan_entry(STAGE);
        end
        else
        begin
            x_next = x_in + (y_in >>> STAGE);
            y_next = y_in - (x_in >>> STAGE);
            z_next = z_in + pfsc_pkg::atan_entry(STAGE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
    assign side_out = side_reg;
endmodule
`default_nettype wire

/* design/pfsc_divider.sv */
// Pipelined restoring divider: one quotient bit per stage.
// Carries a side payload alongside. No package use.
`default_nettype none
module pfsc_divider #(
    parameter int QBITS = 15,
    parameter int DBITS = 31,
    parameter int SIDE_BITS = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  advance,
    input  wire logic                  valid_in,
    input  wire logic [DBITS+QBITS-1:0] num_in,
    input  wire logic [DBITS-1:0]      den_in,
    input  wire logic [SIDE_BITS-1:0]  side_in,
    output logic                       valid_out,
    output logic [QBITS-1:0]           quo_out,
    output logic [SIDE_BITS-1:0]       side_out
);
    localparam int NB = DBITS + QBITS;
    logic [QBITS-1:0] valid_reg, valid_src;
    logic [NB-1:0] rem_reg [QBITS];
    logic [NB-1:0] rem_src [QBITS];
    logic [NB-1:0] rem_next [QBITS];
    logic [DBITS-1:0] den_reg [QBITS];
    logic [DBITS-1:0] den_src [QBITS];
    logic [QBITS-1:0] quo_reg [QBITS];
    logic [QBITS-1:0] quo_src [QBITS];
    logic [QBITS-1:0] quo_next [QBITS];
    logic [SIDE_BITS-1:0] side_reg [QBITS];
    logic [SIDE_BITS-1:0] side_src [QBITS];

    // stage k decides quotient bit QBITS-1-k
    always_comb
    begin
        valid_src[0] = valid_in;
        rem_src[0] = num_in;
        den_src[0] = den_in;
        quo_src[0] = '0;
        side_src[0] = side_in;
        for (int k = 1; k < QBITS; k++)
        begin
            valid_src[k] = valid_reg[k-1];
            rem_src[k] = rem_reg[k-1];
            den_src[k] = den_reg[k-1];
            quo_src[k] = quo_reg[k-1];
            side_src[k] = side_reg[k-1];
        end
        for (int k = 0; k < QBITS; k++)
        begin
            if ((rem_src[k] >> (QBITS - 1 - k)) >= {{QBITS{1'b0}}, den_src[k]})
            begin
                rem_next[k] = rem_src[k] - ({{QBITS{1'b0}}, den_src[k]} << (QBITS - 1 - k));
                quo_next[k] = quo_src[k] | (QBITS'(1) << (QBITS - 1 - k));
            end
            else
            begin
                rem_next[k] = rem_src[k];
                quo_next[k] = quo_src[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= valid_src;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < QBITS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_src[k];
                quo_reg[k] <= quo_next[k];
                side_reg[k] <= side_src[k];
            end
        end
    end

    assign valid_out = valid_reg[QBITS-1];
    assign quo_out = quo_reg[QBITS-1];
    assign side_out = side_reg[QBITS-1];
endmodule
`default_nettype wire
